FILE: design/assert_macros.svh
// Assertion helpers shared by the timer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge while reset is low.
`define CTMR_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("timer assertion failed");

// Checked at every rising edge, reset included.
`define CTMR_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("timer assertion failed");

`endif

FILE: design/ctmr_pkg.sv
`default_nettype none

package ctmr_pkg;

   localparam int PRESET_W    = 10;
   localparam int TENTHS_W    = 4;
   localparam int ALARM_SEC_W = 3;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 10;

   localparam logic [PRESET_W-1:0]    LONG_PRESET_RESET  = 10'd240;
   localparam logic [PRESET_W-1:0]    SHORT_PRESET_RESET = 10'd120;
   localparam logic [TENTHS_W-1:0]    LAST_TENTH         = 4'd9;
   localparam logic [TENTHS_W-1:0]    BLINK_LAST_TENTH   = 4'd5;
   localparam logic [ALARM_SEC_W-1:0] ALARM_SECONDS      = 3'd5;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PRESET  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHORT_PRESET = 1'b1;

   // Button positions in the held-button vector.
   localparam int BTN_SWAP    = 0;
   localparam int BTN_RELOAD  = 1;
   localparam int BTN_RUN     = 2;
   localparam int BTN_CAPTURE = 3;

   typedef enum logic [1:0] {
      MODE_PAUSE = 2'd0,
      MODE_RUN   = 2'd1,
      MODE_WARN  = 2'd2,
      MODE_END   = 2'd3
   } mode_type;

   typedef struct packed {
      logic swap_button;
      logic reload_button;
      logic run_button;
      logic capture_button;
   } ctmr_req_type;

   typedef struct packed {
      logic [PRESET_W-1:0] remaining_time;
      logic [PRESET_W-1:0] captured_time;
      logic [1:0]          run_mode;
      logic                alarm_on;
   } ctmr_rsp_type;

endpackage

`default_nettype wire

FILE: design/ctmr_core.sv
`default_nettype none

`include "assert_macros.svh"

module ctmr_core import ctmr_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire ctmr_req_type           req_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output ctmr_rsp_type                result
);

   logic [PRESET_W-1:0]    long_preset_ff,  long_preset_in;
   logic [PRESET_W-1:0]    short_preset_ff, short_preset_in;
   mode_type               mode_ff,         mode_in;
   logic [PRESET_W-1:0]    time_ff,         time_in;
   logic [PRESET_W-1:0]    captured_ff,     captured_in;
   logic [TENTHS_W-1:0]    tenths_ff,       tenths_in;
   logic [ALARM_SEC_W-1:0] alarm_sec_ff,    alarm_sec_in;
   logic                   short_sel_ff,    short_sel_in;
   logic [3:0]             buttons_ff,      buttons_in;

   logic [3:0]          held;
   logic [3:0]          released;
   logic                reload;
   logic                wrap;
   logic                time_zero;
   logic                count_down;
   logic [PRESET_W-1:0] time_cnt;
   mode_type            mode_cnt;

   assign held[BTN_SWAP]    = req_data.swap_button;
   assign held[BTN_RELOAD]  = req_data.reload_button;
   assign held[BTN_RUN]     = req_data.run_button;
   assign held[BTN_CAPTURE] = req_data.capture_button;

   // A button acts when it goes from held to not held.
   assign released   = buttons_ff & ~held;
   assign reload     = released[BTN_SWAP] | released[BTN_RELOAD];
   assign wrap       = (tenths_ff >= LAST_TENTH);
   assign time_zero  = (time_ff == '0);
   assign count_down = (mode_ff == MODE_RUN) && !time_zero;
   assign time_cnt   = count_down ? time_ff - PRESET_W'(1) : time_ff;

   // Configuration registers.
   always_comb begin
      long_preset_in  = long_preset_ff;
      short_preset_in = short_preset_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_LONG_PRESET:  long_preset_in  = csr_wdata[PRESET_W-1:0];
            CSR_SHORT_PRESET: short_preset_in = csr_wdata[PRESET_W-1:0];
            default: ;
         endcase
      end
   end

   // Mode next state: countdown effects first, then the buttons.
   always_comb begin
      mode_cnt = mode_ff;
      if (wrap && (mode_ff == MODE_WARN) && (alarm_sec_ff >= ALARM_SECONDS)) begin
         mode_cnt = MODE_END;
      end
      if ((mode_ff == MODE_RUN) && time_zero) begin
         mode_cnt = MODE_WARN;
      end
      mode_in = mode_cnt;
      if (reload) begin
         mode_in = MODE_PAUSE;
      end else if (released[BTN_RUN]) begin
         case (mode_cnt)
            MODE_RUN:   mode_in = MODE_PAUSE;
            MODE_PAUSE: mode_in = MODE_RUN;
            default:    mode_in = mode_cnt;
         endcase
      end
   end

   // Counters and captured time.
   always_comb begin
      if (reload || wrap) begin
         tenths_in = '0;
      end else begin
         tenths_in = tenths_ff + TENTHS_W'(1);
      end

      if ((mode_ff == MODE_RUN) && time_zero) begin
         alarm_sec_in = '0;
      end else if (wrap && (mode_ff == MODE_WARN) && (alarm_sec_ff < ALARM_SECONDS)) begin
         alarm_sec_in = alarm_sec_ff + ALARM_SEC_W'(1);
      end else begin
         alarm_sec_in = alarm_sec_ff;
      end

      short_sel_in = short_sel_ff ^ released[BTN_SWAP];
      buttons_in   = held;

      if (reload) begin
         time_in     = short_sel_in ? short_preset_ff : long_preset_ff;
         captured_in = '0;
      end else begin
         time_in     = time_cnt;
         captured_in = released[BTN_CAPTURE] ? time_cnt : captured_ff;
      end
   end

   // Result of the tick, taken from the state after the update.
   always_comb begin
      result.remaining_time = time_in;
      result.captured_time  = captured_in;
      result.run_mode       = mode_in;
      result.alarm_on       = (mode_in == MODE_WARN) && (alarm_sec_in < ALARM_SECONDS) &&
                              (tenths_in <= BLINK_LAST_TENTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         long_preset_ff  <= LONG_PRESET_RESET;
         short_preset_ff <= SHORT_PRESET_RESET;
      end else begin
         long_preset_ff  <= long_preset_in;
         short_preset_ff <= short_preset_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PAUSE;
         time_ff      <= LONG_PRESET_RESET;
         captured_ff  <= '0;
         tenths_ff    <= '0;
         alarm_sec_ff <= '0;
         short_sel_ff <= 1'b0;
         buttons_ff   <= '0;
      end else if (accept) begin
         mode_ff      <= mode_in;
         time_ff      <= time_in;
         captured_ff  <= captured_in;
         tenths_ff    <= tenths_in;
         alarm_sec_ff <= alarm_sec_in;
         short_sel_ff <= short_sel_in;
         buttons_ff   <= buttons_in;
      end
   end

   `CTMR_ASSERT(a_alarm_sec_bounded, clock, reset, alarm_sec_ff <= ALARM_SECONDS)
   `CTMR_ASSERT(a_tenths_bounded, clock, reset, tenths_ff <= LAST_TENTH)
   `CTMR_ASSERT(a_alarm_modes_at_zero, clock, reset, ((mode_ff == MODE_WARN) || (mode_ff == MODE_END)) |-> time_zero)

endmodule

`default_nettype wire

FILE: design/ctmr_out_buf.sv
`default_nettype none

`include "assert_macros.svh"

module ctmr_out_buf import ctmr_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire ctmr_rsp_type push_data,
   output logic              push_ready,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output ctmr_rsp_type      rsp_data
);

   logic         main_valid_ff, main_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   ctmr_rsp_type main_data_ff,  main_data_in;
   ctmr_rsp_type skid_data_ff,  skid_data_in;
   logic         pop;

   assign pop        = main_valid_ff && rsp_ready;
   assign push_ready = !skid_valid_ff;
   assign rsp_valid  = main_valid_ff;
   assign rsp_data   = main_data_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_data_in  = main_data_ff;
      skid_data_in  = skid_data_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_data_in  = skid_data_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         skid_data_in  = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   `CTMR_ASSERT(a_skid_needs_main, clock, reset, skid_valid_ff |-> main_valid_ff)
   `CTMR_ASSERT(a_stall_push_to_skid, clock, reset, (main_valid_ff && !rsp_ready && push) |=> skid_valid_ff)
   `CTMR_ASSERT(a_skid_drains, clock, reset, (skid_valid_ff && rsp_ready) |=> !skid_valid_ff)

endmodule

`default_nettype wire

FILE: design/countdown_timer_with_alarm_unit.sv
`default_nettype none

// Shot-clock countdown timer with alarm. Every transfer on the req_ channel is one
// 100 ms tick carrying the held levels of four buttons, and each tick yields exactly
// one transfer on the rsp_ channel showing the state after that tick: the remaining
// time, the last captured time, the run mode (pause, running, warning, ended) and the
// alarm drive. Buttons act on release: swap toggles between the long and short preset
// and reloads, reload reloads, run toggles running and pause, and capture latches the
// remaining time. A reload wins over every other release in the same tick. After the
// countdown reaches zero the alarm blinks for the first six tenths of each second for
// five seconds, then the mode goes to ended until the next reload. The two presets are
// written through the csr_ port (index 0 long, index 1 short) and take effect at the
// next reload. One tick is accepted every clock cycle while req_ready is high: the whole
// state update is a few narrow counters and compares in combinational logic, and a
// two-entry output buffer lets a new tick in while a finished result still waits on
// rsp_ready. With rsp_ready high, each result is offered on rsp_ in the cycle after its tick.

module countdown_timer_with_alarm_unit import ctmr_pkg::*; (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire ctmr_req_type           req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output ctmr_rsp_type                rsp_data,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic         accept;
   ctmr_rsp_type tick_result;

   // The state advances only on a tick transfer.
   assign accept = req_valid && req_ready;

   ctmr_core u_core (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .result       (tick_result)
   );

   // The result is registered here; the skid entry takes one more result while the
   // output stalls, and req_ready drops while that entry is full.
   ctmr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (tick_result),
      .push_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
